// ===== rtl/core/bfm2d_pkg.sv =====
package bfm2d_pkg;

   // frame and kernel limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_KERNEL = 7;

   // field and counter widths
   localparam int PIX_W    = 8;
   localparam int DIM_W    = 11;
   localparam int KER_W    = 3;
   localparam int RAD_W    = 2;
   localparam int COL_W    = 10;
   localparam int SLOT_W   = 3;
   localparam int CNT_W    = 21;
   localparam int SUM_W    = 14;
   localparam int DIVS_W   = 6;
   localparam int ADDR_W   = SLOT_W + COL_W;
   localparam int LS_DEPTH = MAX_KERNEL * MAX_WIDTH;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL = 2'd2;

   // item operations
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // divider request
   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  dividend;
      logic [DIVS_W-1:0] divisor;
   } div_req_type;

   // divider response
   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/core/bfm2d_stream_if.sv =====
interface bfm2d_req_if;
   logic                        valid;
   logic                        ready;
   logic                        operation;
   logic [bfm2d_pkg::PIX_W-1:0] pixel_in;

   modport source (output valid, output operation, output pixel_in, input ready);
   modport sink (input valid, input operation, input pixel_in, output ready);
endinterface

interface bfm2d_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bfm2d_pkg::PIX_W-1:0] pixel_out;
   logic                        frame_last;

   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ===== rtl/core/bfm2d_ram.sv =====
module bfm2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bfm2d_div.sv =====
module bfm2d_div (
   input  logic                   clock,
   input  logic                   reset,
   input  bfm2d_pkg::div_req_type req,
   output bfm2d_pkg::div_rsp_type rsp
);

   logic [bfm2d_pkg::SUM_W-1:0]  quo_ff, quo_in;
   logic [bfm2d_pkg::DIVS_W-1:0] rem_ff, rem_in;
   logic [bfm2d_pkg::DIVS_W-1:0] dvs_ff, dvs_in;
   logic [3:0]                   cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [bfm2d_pkg::DIVS_W:0]   shifted;
   logic [bfm2d_pkg::DIVS_W:0]   trial;

   // restoring division, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[bfm2d_pkg::SUM_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[bfm2d_pkg::DIVS_W]) begin
            rem_in = trial[bfm2d_pkg::DIVS_W-1:0];
            quo_in = {quo_ff[bfm2d_pkg::SUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[bfm2d_pkg::DIVS_W-1:0];
            quo_in = {quo_ff[bfm2d_pkg::SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(bfm2d_pkg::SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== rtl/core/box_filter_mean_2d_unit.sv =====
// Sequence: an accepted item passes a decide step. A border pixel then reads its own line-store
//   pixel (S = 1) and passes it on; an interior pixel (S = 2*(k/2)+1) reads one line-store entry per
//   window pixel, S*S in all, then goes through a serial divide. Items causing no result go back to idle.
// Throughput: one item at a time; the next item is taken once the current one finishes.
// Reset: counters clear, registers return to width 512, height 512, kernel 3; line store
//   contents are left as they are.
module box_filter_mean_2d_unit (
   input  logic                                clock,
   input  logic                                reset,
   bfm2d_req_if.sink                           req_if,
   bfm2d_rsp_if.source                         rsp_if,
   input  logic                                csr_write_enable,
   input  logic [bfm2d_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bfm2d_pkg::DIM_W-1:0]         csr_write_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_ACC    = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_OUT    = 3'd5;

   localparam logic [bfm2d_pkg::SLOT_W-1:0] LAST_SLOT =
      bfm2d_pkg::SLOT_W'(bfm2d_pkg::MAX_KERNEL - 1);

   // configuration registers
   logic [bfm2d_pkg::DIM_W-1:0] cfg_width_ff, cfg_height_ff;
   logic [bfm2d_pkg::KER_W-1:0] cfg_kernel_ff;

   // effective settings
   logic [bfm2d_pkg::DIM_W-1:0]  eff_w, eff_h;
   logic [bfm2d_pkg::KER_W-1:0]  eff_k;
   logic [bfm2d_pkg::RAD_W-1:0]  rad;
   logic [bfm2d_pkg::CNT_W-1:0]  total_ff, delay_ff;
   logic [bfm2d_pkg::DIVS_W-1:0] divisor;

   // frame counters
   logic [bfm2d_pkg::DIM_W-1:0]  in_row_ff, in_row_in;
   logic [bfm2d_pkg::COL_W-1:0]  in_col_ff, in_col_in;
   logic [bfm2d_pkg::SLOT_W-1:0] in_slot_ff, in_slot_in;
   logic [bfm2d_pkg::CNT_W-1:0]  in_cnt_ff, in_cnt_in;
   logic [bfm2d_pkg::CNT_W-1:0]  out_idx_ff, out_idx_in;
   logic [bfm2d_pkg::COL_W-1:0]  out_y_ff, out_y_in;
   logic [bfm2d_pkg::COL_W-1:0]  out_x_ff, out_x_in;
   logic [bfm2d_pkg::SLOT_W-1:0] out_slot_ff, out_slot_in;

   // window walk
   logic [bfm2d_pkg::SLOT_W-1:0] win_slot_ff, win_slot_in;
   logic [bfm2d_pkg::COL_W-1:0]  win_x0_ff, win_x0_in;
   logic [bfm2d_pkg::COL_W-1:0]  win_x_ff, win_x_in;
   logic [2:0]                   win_cx_ff, win_cx_in;
   logic [2:0]                   win_cy_ff, win_cy_in;
   logic [2:0]                   side_ff, side_in;
   logic                         interior_ff, interior_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic [bfm2d_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [bfm2d_pkg::PIX_W-1:0]  res_ff, res_in;

   logic [2:0] state_ff, state_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bfm2d_pkg::PIX_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic                        rsp_last_ff, rsp_last_in;

   // memory and divider hookup
   logic                         ram_wr_en, ram_rd_en;
   logic [bfm2d_pkg::ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [bfm2d_pkg::PIX_W-1:0]  ram_rd_data;
   bfm2d_pkg::div_req_type       div_req;
   bfm2d_pkg::div_rsp_type       div_rsp;

   // scratch
   logic                         accept, emit, interior, last_px, csr_restart;
   logic [bfm2d_pkg::DIM_W:0]    col_next;
   logic [bfm2d_pkg::CNT_W-1:0]  out_idx_next;
   logic [bfm2d_pkg::DIM_W:0]    oy_far, ox_far, ox_next;
   logic [3:0]                   slot_sum;
   logic [bfm2d_pkg::SUM_W-1:0]  acc_sum;

   // clamped settings
   always_comb begin
      eff_w = cfg_width_ff;
      if (cfg_width_ff == '0) eff_w = bfm2d_pkg::DIM_W'(1);
      else if (cfg_width_ff > bfm2d_pkg::DIM_W'(bfm2d_pkg::MAX_WIDTH))
         eff_w = bfm2d_pkg::DIM_W'(bfm2d_pkg::MAX_WIDTH);
      eff_h = cfg_height_ff;
      if (cfg_height_ff == '0) eff_h = bfm2d_pkg::DIM_W'(1);
      else if (cfg_height_ff > bfm2d_pkg::DIM_W'(bfm2d_pkg::MAX_HEIGHT))
         eff_h = bfm2d_pkg::DIM_W'(bfm2d_pkg::MAX_HEIGHT);
      eff_k = (cfg_kernel_ff == '0) ? bfm2d_pkg::KER_W'(1) : cfg_kernel_ff;
      rad   = eff_k[bfm2d_pkg::KER_W-1:1];
      divisor = bfm2d_pkg::DIVS_W'(eff_k * eff_k);
   end

   // config registers and frame size products
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= bfm2d_pkg::DIM_W'(512);
         cfg_height_ff <= bfm2d_pkg::DIM_W'(512);
         cfg_kernel_ff <= bfm2d_pkg::KER_W'(3);
      end else if (csr_write_enable) begin
         case (csr_index)
            bfm2d_pkg::REG_WIDTH:  cfg_width_ff  <= csr_write_data;
            bfm2d_pkg::REG_HEIGHT: cfg_height_ff <= csr_write_data;
            bfm2d_pkg::REG_KERNEL: cfg_kernel_ff <= csr_write_data[bfm2d_pkg::KER_W-1:0];
            default: ;
         endcase
      end
      total_ff <= bfm2d_pkg::CNT_W'(eff_w * eff_h);
      delay_ff <= bfm2d_pkg::CNT_W'(eff_w * rad) + bfm2d_pkg::CNT_W'(rad);
   end

   // only a write to a known register restarts the frame
   assign csr_restart = csr_write_enable &&
                        (csr_index inside {bfm2d_pkg::REG_WIDTH, bfm2d_pkg::REG_HEIGHT,
                                           bfm2d_pkg::REG_KERNEL});

   assign accept = (state_ff == ST_IDLE) && req_if.valid;
   assign req_if.ready = (state_ff == ST_IDLE);

   // window test for the current output position
   assign oy_far = {2'b0, out_y_ff} + {{(bfm2d_pkg::DIM_W-1){1'b0}}, rad};
   assign ox_far = {2'b0, out_x_ff} + {{(bfm2d_pkg::DIM_W-1){1'b0}}, rad};
   assign interior = (out_y_ff >= bfm2d_pkg::COL_W'(rad)) && (oy_far < {1'b0, eff_h}) &&
                     (out_x_ff >= bfm2d_pkg::COL_W'(rad)) && (ox_far < {1'b0, eff_w});
   assign emit = (out_idx_ff < total_ff) &&
                 ((in_cnt_ff == total_ff) || (out_idx_ff + delay_ff < in_cnt_ff));
   assign slot_sum = {1'b0, out_slot_ff} + 4'(bfm2d_pkg::MAX_KERNEL) - {2'b0, rad};
   assign col_next = {2'b0, in_col_ff} + 12'd1;
   assign out_idx_next = out_idx_ff + bfm2d_pkg::CNT_W'(1);
   assign last_px = (out_idx_next >= total_ff);
   assign ox_next = {2'b0, out_x_ff} + 12'd1;
   assign acc_sum = sum_ff + bfm2d_pkg::SUM_W'(ram_rd_data);

   // item sequencer
   always_comb begin
      state_in     = state_ff;
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      in_slot_in   = in_slot_ff;
      in_cnt_in    = in_cnt_ff;
      out_idx_in   = out_idx_ff;
      out_y_in     = out_y_ff;
      out_x_in     = out_x_ff;
      out_slot_in  = out_slot_ff;
      win_slot_in  = win_slot_ff;
      win_x0_in    = win_x0_ff;
      win_x_in     = win_x_ff;
      win_cx_in    = win_cx_ff;
      win_cy_in    = win_cy_ff;
      side_in      = side_ff;
      interior_in  = interior_ff;
      rd_pend_in   = 1'b0;
      sum_in       = sum_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = {in_slot_ff, in_col_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = {win_slot_ff, win_x_ff};
      div_req.start    = 1'b0;
      div_req.dividend = acc_sum;
      div_req.divisor  = divisor;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // store an in-frame pixel and advance the input position; a drain stores nothing
               if (req_if.operation == bfm2d_pkg::OP_PIXEL && in_row_ff < eff_h &&
                   {1'b0, in_col_ff} < eff_w) begin
                  ram_wr_en = 1'b1;
                  in_cnt_in = in_cnt_ff + bfm2d_pkg::CNT_W'(1);
                  if (col_next >= {1'b0, eff_w}) begin
                     in_col_in  = '0;
                     in_row_in  = in_row_ff + bfm2d_pkg::DIM_W'(1);
                     in_slot_in = (in_slot_ff == LAST_SLOT) ? '0 :
                                  in_slot_ff + bfm2d_pkg::SLOT_W'(1);
                  end else begin
                     in_col_in = col_next[bfm2d_pkg::COL_W-1:0];
                  end
               end
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!emit) begin
               state_in = ST_IDLE;
            end else begin
               interior_in = interior;
               win_cx_in   = '0;
               win_cy_in   = '0;
               sum_in      = '0;
               if (interior) begin
                  win_slot_in = (slot_sum >= 4'(bfm2d_pkg::MAX_KERNEL)) ?
                                bfm2d_pkg::SLOT_W'(slot_sum - 4'(bfm2d_pkg::MAX_KERNEL)) :
                                bfm2d_pkg::SLOT_W'(slot_sum);
                  win_x0_in   = out_x_ff - bfm2d_pkg::COL_W'(rad);
                  win_x_in    = out_x_ff - bfm2d_pkg::COL_W'(rad);
                  side_in     = {rad, 1'b1};
               end else begin
                  win_slot_in = out_slot_ff;
                  win_x0_in   = out_x_ff;
                  win_x_in    = out_x_ff;
                  side_in     = 3'd1;
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // one line-store read per cycle; each read is added to the sum once the RAM's registered output holds it
            ram_rd_en  = 1'b1;
            rd_pend_in = 1'b1;
            if (rd_pend_ff) sum_in = acc_sum;
            if (win_cx_ff == side_ff - 3'd1) begin
               win_cx_in = '0;
               win_x_in  = win_x0_ff;
               if (win_cy_ff == side_ff - 3'd1) begin
                  state_in = ST_ACC;
               end else begin
                  win_cy_in   = win_cy_ff + 3'd1;
                  win_slot_in = (win_slot_ff == LAST_SLOT) ? '0 :
                                win_slot_ff + bfm2d_pkg::SLOT_W'(1);
               end
            end else begin
               win_cx_in = win_cx_ff + 3'd1;
               win_x_in  = win_x_ff + bfm2d_pkg::COL_W'(1);
            end
         end
         ST_ACC: begin
            sum_in = acc_sum;
            if (interior_ff) begin
               div_req.start = 1'b1;
               state_in = ST_DIV;
            end else begin
               res_in   = ram_rd_data;
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               res_in = (|div_rsp.quotient[bfm2d_pkg::SUM_W-1:bfm2d_pkg::PIX_W]) ?
                        {bfm2d_pkg::PIX_W{1'b1}} :
                        div_rsp.quotient[bfm2d_pkg::PIX_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = res_ff;
               rsp_last_in  = last_px;
               out_idx_in   = out_idx_next;
               if (ox_next >= {1'b0, eff_w}) begin
                  out_x_in    = '0;
                  out_y_in    = out_y_ff + bfm2d_pkg::COL_W'(1);
                  out_slot_in = (out_slot_ff == LAST_SLOT) ? '0 :
                                out_slot_ff + bfm2d_pkg::SLOT_W'(1);
               end else begin
                  out_x_in = ox_next[bfm2d_pkg::COL_W-1:0];
               end
               if (last_px) begin
                  in_row_in   = '0;
                  in_col_in   = '0;
                  in_slot_in  = '0;
                  in_cnt_in   = '0;
                  out_idx_in  = '0;
                  out_y_in    = '0;
                  out_x_in    = '0;
                  out_slot_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and counter registers
   always_ff @(posedge clock) begin
      if (reset || csr_restart) begin
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         in_slot_ff  <= '0;
         in_cnt_ff   <= '0;
         out_idx_ff  <= '0;
         out_y_ff    <= '0;
         out_x_ff    <= '0;
         out_slot_ff <= '0;
      end else begin
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         in_slot_ff  <= in_slot_in;
         in_cnt_ff   <= in_cnt_in;
         out_idx_ff  <= out_idx_in;
         out_y_ff    <= out_y_in;
         out_x_ff    <= out_x_in;
         out_slot_ff <= out_slot_in;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
      end
      win_slot_ff  <= win_slot_in;
      win_x0_ff    <= win_x0_in;
      win_x_ff     <= win_x_in;
      win_cx_ff    <= win_cx_in;
      win_cy_ff    <= win_cy_in;
      side_ff      <= side_in;
      interior_ff  <= interior_in;
      sum_ff       <= sum_in;
      res_ff       <= res_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pixel_out  = rsp_pixel_ff;
   assign rsp_if.frame_last = rsp_last_ff;

   // line store: MAX_KERNEL rows of MAX_WIDTH pixels
   bfm2d_ram #(
      .WIDTH (bfm2d_pkg::PIX_W),
      .DEPTH (bfm2d_pkg::LS_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_if.pixel_in),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // window mean divider
   bfm2d_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

endmodule
